// ===== src/lsf_pkg.sv =====
// Shared types and constants of the learning switch forwarder.
package lsf_pkg;

	localparam int PORTS_DEF       = 8;
	localparam int TABLE_DEPTH_DEF = 16;
	localparam int MAC_W           = 48;
	localparam int AGE_W           = 16;
	localparam int PNUM_W          = 3;
	localparam int MASK_W          = 8;
	localparam int GROUP_BIT       = 40;

	localparam logic [AGE_W-1:0] LIFETIME_RST = 16'd300;
	localparam logic [MAC_W-1:0] OWN_MAC_RST   = 48'h4242_4242_4222;
	localparam logic [MAC_W-1:0] PROBE_MAC_RST = 48'h0180_C200_0005;

	typedef enum logic [1:0] {
		REG_LIFETIME  = 2'd0,
		REG_OWN_MAC   = 2'd1,
		REG_PROBE_MAC = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_UNICAST = 3'd0,
		ST_FLOOD   = 3'd1,
		ST_BLOCKED = 3'd2,
		ST_PROBE   = 3'd3,
		ST_INVALID = 3'd4
	} status_t;

	// one classified frame header waiting for the table engine
	typedef struct packed {
		logic                fwd;
		status_t             st;
		logic [PNUM_W-1:0]   in_port;
		logic [MAC_W-1:0]    dst_mac;
		logic [MAC_W-1:0]    src_mac;
		logic [MASK_W-1:0]   flood;
	} qent_t;

	typedef struct packed {
		logic                valid;
		logic [MAC_W-1:0]    mac;
		logic [PNUM_W-1:0]   port;
		logic [AGE_W-1:0]    age;
	} tent_t;

endpackage

// ===== src/lsf_fifo.sv =====
// Two-entry queue between the classifier and the table engine.
module lsf_fifo
	import lsf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_data,
	output logic  full,
	output logic  q_valid,
	output qent_t q_data,
	input  logic  pop
);

	qent_t      buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_data  = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== src/lsf_front.sv =====
// Classifier: port blocking, source check, loop probe handling.
module lsf_front
	import lsf_pkg::*;
#(
	parameter int PORTS = PORTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [PNUM_W-1:0] in_port,
	input  logic [MAC_W-1:0]  dst_mac,
	input  logic [MAC_W-1:0]  src_mac,
	input  logic [PNUM_W-1:0] probe_port,
	input  logic [MAC_W-1:0]  own_mac,
	input  logic [MAC_W-1:0]  probe_mac,
	output qent_t             ent
);

	logic [PORTS-1:0] port_open_q;
	logic [15:0]      open_ext;
	logic [15:0]      clr;
	logic             is_probe;

	assign open_ext = 16'(port_open_q);
	assign clr      = 16'd1 << probe_port;
	assign is_probe = (dst_mac == probe_mac) && (src_mac == own_mac);

	always_comb begin
		ent.fwd     = 1'b0;
		ent.st      = ST_FLOOD;
		ent.in_port = in_port;
		ent.dst_mac = dst_mac;
		ent.src_mac = src_mac;
		ent.flood   = open_ext[MASK_W-1:0] & ~(8'd1 << in_port);
		// ports at or above PORTS read as closed
		if (!open_ext[{1'b0, in_port}])
			ent.st = ST_BLOCKED;
		else if (src_mac[GROUP_BIT])
			ent.st = ST_INVALID;
		else if (is_probe)
			ent.st = ST_PROBE;
		else
			ent.fwd = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_open_q <= '1;
		end else if (take && !ent.fwd && ent.st == ST_PROBE && 32'(probe_port) < PORTS) begin
			port_open_q <= port_open_q & ~clr[PORTS-1:0];
		end
	end

endmodule

// ===== src/lsf_back.sv =====
// Table engine: clearing pass, aging sweep, learn write and result register.
module lsf_back
	import lsf_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  qent_t             q_data,
	output logic              q_pop,
	input  logic [AGE_W-1:0]  lifetime,
	output logic              init_done,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [MASK_W-1:0] egress_mask,
	output logic [2:0]        status
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {S_INIT, S_IDLE, S_SWEEP, S_LEARN} state_t;

	state_t            state_q;
	tent_t             mem_q [TABLE_DEPTH];
	tent_t             rd_data_q;
	logic [AW-1:0]     raddr;
	logic              we;
	logic [AW-1:0]     waddr;
	tent_t             wdata;

	logic [CW-1:0]     rd_idx_q;
	logic [AW-1:0]     chk_idx_q;
	qent_t             cur_q;
	logic              src_hit_q, free_hit_q, dst_hit_q;
	logic [AW-1:0]     src_idx_q, free_idx_q;
	logic [PNUM_W-1:0] dst_port_q;
	logic              out_valid_q;
	logic [MASK_W-1:0] egress_mask_q;
	status_t           status_q;

	logic              alive;
	tent_t             aged;
	logic              learned;

	assign alive = rd_data_q.valid && (rd_data_q.age > 16'd1);
	always_comb begin
		aged       = rd_data_q;
		aged.valid = alive;
		aged.age   = alive ? rd_data_q.age - 16'd1 : '0;
	end

	assign learned     = src_hit_q || free_hit_q;
	assign q_pop       = (state_q == S_IDLE) && q_valid && !out_valid_q;
	assign init_done   = (state_q != S_INIT);
	assign out_valid   = out_valid_q;
	assign egress_mask = egress_mask_q;
	assign status      = status_q;
	assign raddr       = (state_q == S_IDLE) ? '0 : rd_idx_q[AW-1:0];

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		unique case (state_q)
			S_INIT: begin
				we    = 1'b1;
				waddr = rd_idx_q[AW-1:0];
			end
			S_SWEEP: begin
				we    = 1'b1;
				waddr = chk_idx_q;
				wdata = aged;
			end
			S_LEARN: begin
				we          = learned;
				waddr       = src_hit_q ? src_idx_q : free_idx_q;
				wdata.valid = 1'b1;
				wdata.mac   = cur_q.src_mac;
				wdata.port  = cur_q.in_port;
				wdata.age   = lifetime;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rd_data_q <= mem_q[raddr];
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			rd_idx_q      <= '0;
			chk_idx_q     <= '0;
			src_hit_q     <= 1'b0;
			free_hit_q    <= 1'b0;
			dst_hit_q     <= 1'b0;
			src_idx_q     <= '0;
			free_idx_q    <= '0;
			dst_port_q    <= '0;
			out_valid_q   <= 1'b0;
			egress_mask_q <= '0;
			status_q      <= ST_UNICAST;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					if (rd_idx_q == CW'(TABLE_DEPTH - 1)) begin
						rd_idx_q <= '0;
						state_q  <= S_IDLE;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (q_pop) begin
						if (q_data.fwd) begin
							// read of entry 0 goes out this cycle
							rd_idx_q   <= CW'(1);
							chk_idx_q  <= '0;
							src_hit_q  <= 1'b0;
							free_hit_q <= 1'b0;
							dst_hit_q  <= 1'b0;
							state_q    <= S_SWEEP;
						end else begin
							out_valid_q   <= 1'b1;
							egress_mask_q <= '0;
							status_q      <= q_data.st;
						end
					end
				end
				S_SWEEP: begin
					rd_idx_q  <= rd_idx_q + 1'b1;
					chk_idx_q <= chk_idx_q + 1'b1;
					if (alive && rd_data_q.mac == cur_q.src_mac && !src_hit_q) begin
						src_hit_q <= 1'b1;
						src_idx_q <= chk_idx_q;
					end
					if (!alive && !free_hit_q) begin
						free_hit_q <= 1'b1;
						free_idx_q <= chk_idx_q;
					end
					if (alive && rd_data_q.mac == cur_q.dst_mac && !dst_hit_q) begin
						dst_hit_q  <= 1'b1;
						dst_port_q <= rd_data_q.port;
					end
					if (chk_idx_q == AW'(TABLE_DEPTH - 1))
						state_q <= S_LEARN;
				end
				S_LEARN: begin
					out_valid_q <= 1'b1;
					status_q    <= ST_UNICAST;
					// a frame to its own source follows the just-learned port
					if (learned && cur_q.dst_mac == cur_q.src_mac)
						egress_mask_q <= 8'd1 << cur_q.in_port;
					else if (dst_hit_q)
						egress_mask_q <= 8'd1 << dst_port_q;
					else begin
						egress_mask_q <= cur_q.flood;
						status_q      <= ST_FLOOD;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/learning_switch_forwarder.sv =====
// Top level of the learning switch forwarder.
// Learning bridge with an aging MAC table: each transfer on the input channel is one frame
// header, each transfer on the output channel its egress mask and status. After reset the
// table is cleared in a pass over every entry, during which in_ready stays low. Blocked,
// invalid-source and loop-probe frames get their result straight from the queue head, without
// touching the table; forwarded frames go through the aging sweep that reads and rewrites one
// table entry per cycle through the single table memory port pair. A header leaves the queue only
// once the previous result has been taken. A two-entry queue lets new headers be accepted
// while the table engine is busy. Configuration must be written only while no frame is in
// flight.
module learning_switch_forwarder
	import lsf_pkg::*;
#(
	parameter int PORTS       = PORTS_DEF,
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [MAC_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [PNUM_W-1:0] in_port,
	input  logic [MAC_W-1:0]  dst_mac,
	input  logic [MAC_W-1:0]  src_mac,
	input  logic [PNUM_W-1:0] probe_port,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [MASK_W-1:0] egress_mask,
	output logic [2:0]        status
);

	logic [AGE_W-1:0] entry_lifetime_q;
	logic [MAC_W-1:0] own_mac_q;
	logic [MAC_W-1:0] probe_mac_q;

	logic  full, q_valid, q_pop, init_done, take;
	qent_t ent, q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_lifetime_q <= LIFETIME_RST;
			own_mac_q        <= OWN_MAC_RST;
			probe_mac_q      <= PROBE_MAC_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LIFETIME:  entry_lifetime_q <= cfg_wdata[AGE_W-1:0];
				REG_OWN_MAC:   own_mac_q        <= cfg_wdata;
				REG_PROBE_MAC: probe_mac_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_ready = !full && init_done;
	assign take     = in_valid && in_ready;

	lsf_front #(.PORTS(PORTS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.in_port   (in_port),
		.dst_mac   (dst_mac),
		.src_mac   (src_mac),
		.probe_port(probe_port),
		.own_mac   (own_mac_q),
		.probe_mac (probe_mac_q),
		.ent       (ent)
	);

	lsf_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take),
		.push_data(ent),
		.full     (full),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.pop      (q_pop)
	);

	lsf_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.lifetime   (entry_lifetime_q),
		.init_done  (init_done),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.egress_mask(egress_mask),
		.status     (status)
	);

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!init_done |-> !in_ready) else $error("input taken during table clear");

	a_unicast_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_UNICAST |-> $onehot(egress_mask))
		else $error("unicast mask not one-hot");

	a_drop_no_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_BLOCKED || status == ST_PROBE || status == ST_INVALID)
		|-> egress_mask == '0) else $error("dropped frame has egress bits");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("queue popped while empty");

endmodule

// ===== sim/lsf_checker.sv =====
// Checker for the learning switch forwarder: tracks configuration, predicts results, compares.
`timescale 1ns / 100ps
module lsf_checker
	import lsf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [MAC_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [PNUM_W-1:0] in_port,
	input  logic [MAC_W-1:0]  dst_mac,
	input  logic [MAC_W-1:0]  src_mac,
	input  logic [PNUM_W-1:0] probe_port,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [MASK_W-1:0] egress_mask,
	input  logic [2:0]        status,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [MASK_W-1:0] mask;
		status_t           st;
	} fwd_result_t;

	logic [AGE_W-1:0]  lifetime;
	logic [MAC_W-1:0]  own_addr;
	logic [MAC_W-1:0]  probe_addr;
	logic [MASK_W-1:0] open_ports;
	tent_t             mac_table [TABLE_DEPTH_DEF];
	fwd_result_t       expected_q [$];

	assign pending = expected_q.size();

	function automatic int lookup_mac(input logic [MAC_W-1:0] mac);
		for (int i = 0; i < TABLE_DEPTH_DEF; i++)
			if (mac_table[i].valid && mac_table[i].mac == mac)
				return i;
		return -1;
	endfunction

	function automatic fwd_result_t forward_frame(input logic [PNUM_W-1:0] port,
			input logic [MAC_W-1:0] dst, input logic [MAC_W-1:0] src,
			input logic [PNUM_W-1:0] pport);
		fwd_result_t r;
		int          idx;
		r.mask = '0;
		if (!open_ports[port]) begin
			r.st = ST_BLOCKED;
		end else if (src[GROUP_BIT]) begin
			r.st = ST_INVALID;
		end else if (dst == probe_addr && src == own_addr) begin
			open_ports[pport] = 1'b0;
			r.st = ST_PROBE;
		end else begin
			for (int i = 0; i < TABLE_DEPTH_DEF; i++)
				if (mac_table[i].valid) begin
					if (mac_table[i].age <= 1) begin
						mac_table[i].valid = 1'b0;
						mac_table[i].age = '0;
					end else begin
						mac_table[i].age = mac_table[i].age - 1'b1;
					end
				end
			idx = lookup_mac(src);
			if (idx < 0)
				for (int k = 0; k < TABLE_DEPTH_DEF; k++)
					if (!mac_table[k].valid) begin
						idx = k;
						mac_table[k].valid = 1'b1;
						mac_table[k].mac = src;
						break;
					end
			if (idx >= 0) begin
				mac_table[idx].port = port;
				mac_table[idx].age = lifetime;
			end
			idx = lookup_mac(dst);
			if (idx >= 0) begin
				r.mask = MASK_W'(1) << mac_table[idx].port;
				r.st = ST_UNICAST;
			end else begin
				r.mask = open_ports & ~(MASK_W'(1) << port);
				r.st = ST_FLOOD;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fwd_result_t got;
		fwd_result_t exp_r;
		int          errs;
		if (!arst_n) begin
			lifetime   <= LIFETIME_RST;
			own_addr   <= OWN_MAC_RST;
			probe_addr <= PROBE_MAC_RST;
			open_ports = '1;
			for (int i = 0; i < TABLE_DEPTH_DEF; i++)
				mac_table[i] = '0;
			expected_q.delete();
			fail_count <= 0;
		end else begin
			errs = 0;
			if (cfg_we)
				case (reg_idx_t'(cfg_index))
					REG_LIFETIME:  lifetime <= cfg_wdata[AGE_W-1:0];
					REG_OWN_MAC:   own_addr <= cfg_wdata;
					REG_PROBE_MAC: probe_addr <= cfg_wdata;
					default: ;
				endcase
			if (out_valid && out_ready) begin
				got.mask = egress_mask;
				got.st = status_t'(status);
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected transfer: mask %h status %0d",
						$time, egress_mask, status);
					errs++;
				end else begin
					exp_r = expected_q.pop_front();
					if (got.mask !== exp_r.mask) begin
						$display("%0t: egress_mask expected %h actual %h",
							$time, exp_r.mask, got.mask);
						errs++;
					end
					if (got.st !== exp_r.st) begin
						$display("%0t: status expected %0d actual %0d",
							$time, exp_r.st, status);
						errs++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(forward_frame(in_port, dst_mac, src_mac, probe_port));
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Stimulus and verdict for the learning switch forwarder.
`timescale 1ns / 100ps
module testbench;
	import lsf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [MAC_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [PNUM_W-1:0] in_port = '0;
	logic [MAC_W-1:0]  dst_mac = '0;
	logic [MAC_W-1:0]  src_mac = '0;
	logic [PNUM_W-1:0] probe_port = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [MASK_W-1:0] egress_mask;
	logic [2:0]        status;
	int                fail_count;
	int                pending;
	int                cycle_count = 0;
	bit                no_idle = 1'b0;

	// current settings, mirrored so stimulus can build probe frames
	logic [MAC_W-1:0]  cur_own = OWN_MAC_RST;
	logic [MAC_W-1:0]  cur_probe = PROBE_MAC_RST;
	logic [MAC_W-1:0]  addr_pool [12];

	always #2 clk = ~clk;

	learning_switch_forwarder DUT (.*);

	lsf_checker checker_i (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk)
		out_ready <= no_idle || ($urandom_range(99) >= 16);

	task automatic write_reg(input reg_idx_t idx, input logic [MAC_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_OWN_MAC) cur_own = val;
		if (idx == REG_PROBE_MAC) cur_probe = val;
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (TABLE_DEPTH_DEF + 8) @(posedge clk);
	endtask

	// valid stays high between back-to-back frames; wait_quiet drops it
	task automatic send_frame(input logic [PNUM_W-1:0] port, input logic [MAC_W-1:0] dst,
			input logic [MAC_W-1:0] src, input logic [PNUM_W-1:0] pport);
		if (!no_idle && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 16) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_port <= port;
		dst_mac <= dst;
		src_mac <= src;
		probe_port <= pport;
		@(posedge clk iff in_ready);
	endtask

	function automatic logic [MAC_W-1:0] rand_mac();
		return MAC_W'({$urandom, $urandom});
	endfunction

	task automatic random_frame(input int probe_weight);
		logic [MAC_W-1:0] dst;
		logic [MAC_W-1:0] src;
		int               sel;
		sel = $urandom_range(99);
		dst = ($urandom_range(3) != 0) ? addr_pool[$urandom_range(11)] : rand_mac();
		src = ($urandom_range(5) != 0) ? addr_pool[$urandom_range(11)] : rand_mac();
		if (sel < probe_weight) begin
			dst = cur_probe;
			src = cur_own;
		end else if (sel < probe_weight + 3) begin
			dst = cur_probe;
		end
		send_frame(PNUM_W'($urandom_range(7)), dst, src, PNUM_W'($urandom_range(7)));
	endtask

	initial begin
		for (int i = 0; i < 12; i++)
			addr_pool[i] = rand_mac() & ~(48'h1 << GROUP_BIT);
		addr_pool[10] = '1 & ~(48'h1 << GROUP_BIT);
		addr_pool[11] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: learn, unicast, flood, group source, extremes, table overflow
		send_frame(3'd0, 48'd0, 48'h0000_0000_0001, 3'd0);
		send_frame(3'd7, 48'h0000_0000_0001, 48'hFEFF_FFFF_FFFF, 3'd7);
		send_frame(3'd2, 48'hFEFF_FFFF_FFFF, 48'd0, 3'd5);
		send_frame(3'd4, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 3'd1);
		send_frame(3'd5, 48'hFFFF_FFFF_FFFF, 48'h0100_0000_0000, 3'd2);
		for (int i = 0; i < 18; i++)
			send_frame(3'(i), 48'h1234, 48'h0A00_0000_0000 + i, 3'(i));
		// loop probe blocks port 6, then traffic on it is dropped
		send_frame(3'd1, cur_probe, cur_own, 3'd6);
		send_frame(3'd6, 48'd0, 48'd5, 3'd0);
		wait_quiet();

		// short lifetime makes entries expire quickly
		write_reg(REG_LIFETIME, 16'd1);
		write_reg(REG_OWN_MAC, 48'd0);
		write_reg(REG_PROBE_MAC, 48'hFFFF_FFFF_FFFF);
		for (int i = 0; i < 300; i++) random_frame(1);
		wait_quiet();

		write_reg(REG_LIFETIME, 16'd3);
		write_reg(REG_OWN_MAC, addr_pool[3]);
		write_reg(REG_PROBE_MAC, addr_pool[4]);
		no_idle = 1'b1;
		for (int i = 0; i < 400; i++) random_frame(1);
		no_idle = 1'b0;
		wait_quiet();

		write_reg(REG_LIFETIME, 16'hFFFF);
		write_reg(REG_OWN_MAC, rand_mac());
		write_reg(REG_PROBE_MAC, rand_mac());
		for (int i = 0; i < 450; i++) random_frame(1);
		wait_quiet();

		write_reg(REG_LIFETIME, 16'd40);
		for (int i = 0; i < 450; i++) random_frame(2);

		wait_quiet();
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
